// ===== src/u8col_pkg.sv =====
package u8col_pkg;

    localparam int BYTE_W = 8;
    localparam int COL_W  = 16;
    localparam int CP_W   = 21;
    localparam int ADD_W  = 4;

    localparam logic [COL_W-1:0] COL_MAX  = 16'hffff;
    localparam logic [ADD_W-1:0] TAB_STOP = 4'd8;
    localparam logic [CP_W-1:0]  CP_MAX   = 21'h10ffff;
    localparam logic [CP_W-1:0]  SURR_LO  = 21'h00d800;
    localparam logic [CP_W-1:0]  SURR_HI  = 21'h00dfff;
    localparam logic [CP_W-1:0]  MIN_2B   = 21'h000080;
    localparam logic [CP_W-1:0]  MIN_3B   = 21'h000800;
    localparam logic [CP_W-1:0]  MIN_4B   = 21'h010000;
    localparam logic [CP_W-1:0]  CP_TAB   = 21'h000009;

    // class of the pending sequence, which selects its smallest legal value
    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_2B   = 2'd1;
    localparam logic [1:0] CLASS_3B   = 2'd2;
    localparam logic [1:0] CLASS_4B   = 2'd3;

    function automatic logic [COL_W-1:0] sat_add(input logic [COL_W-1:0] t,
                                                 input logic [ADD_W-1:0] n);
        logic [COL_W:0] s;
        s = {1'b0, t} + {{(COL_W+1-ADD_W){1'b0}}, n};
        return s[COL_W] ? COL_MAX : s[COL_W-1:0];
    endfunction

    function automatic logic [1:0] cp_width(input logic [CP_W-1:0] v);
        logic [1:0] w;
        if (v inside {[21'h0300:21'h036f], [21'h1ab0:21'h1aff], [21'h1dc0:21'h1dff],
                      [21'h20d0:21'h20ff], [21'hfe20:21'hfe2f]}) begin
            w = 2'd0;
        end else if (v inside {[21'h1100:21'h115f], [21'h2329:21'h232a],
                               [21'h2e80:21'ha4cf], [21'hac00:21'hd7a3],
                               [21'hf900:21'hfaff], [21'hfe10:21'hfe19],
                               [21'hfe30:21'hfe6f], [21'hff00:21'hff60],
                               [21'hffe0:21'hffe6], [21'h20000:21'h3fffd]}) begin
            w = 2'd2;
        end else begin
            w = 2'd1;
        end
        return w;
    endfunction

    function automatic logic [COL_W-1:0] add_point(input logic [COL_W-1:0] t,
                                                   input logic [CP_W-1:0] v);
        logic [COL_W-1:0] r;
        if (v == CP_TAB) begin
            r = sat_add(t, TAB_STOP - {1'b0, t[2:0]});
        end else begin
            r = sat_add(t, {2'b00, cp_width(v)});
        end
        return r;
    endfunction

endpackage

// ===== src/utf8_display_column_counter_top.sv =====
// UTF-8 display column counter.
// Input stream: one text byte per beat on s_tdata, s_tlast marks the last
// byte of a text. Output stream: one beat per text on m_tdata carrying the
// total display columns (saturating at 65535), sent after the last byte.
// Each byte is decoded against the running UTF-8 sequence state; code
// points add 0, 1 or 2 columns, a tab moves to the next multiple of 8,
// malformed input counts one column per byte, and a NUL stops counting
// until the end of the text.
// Throughput: one byte per clock, but a last byte can wait (see Stalls). A
// byte is held in the input register and folded into the column state
// when it advances; for a last byte that same edge loads the total into
// the output register and raises m_tvalid.
// Stalls: a byte that is not last keeps flowing while a total waits in
// the output register; a last byte waits in the input register until the
// output register is free, which then holds s_tready low.
// Reset (aresetn low, synchronous) empties both registers and clears the
// column count and any pending sequence.
module utf8_display_column_counter_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [u8col_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] text_byte
    input  logic                          s_tlast,   // is_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [u8col_pkg::COL_W-1:0]   m_tdata    // [15:0] columns
);
    import u8col_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              advance;

    logic [COL_W-1:0]  total_reg,  total_next;
    logic [2:0]        need_reg,   need_next;
    logic [2:0]        seen_reg,   seen_next;
    logic [CP_W-1:0]   pv_reg,     pv_next;
    logic [1:0]        mc_reg,     mc_next;
    logic              stop_reg,   stop_next;
    logic [COL_W-1:0]  result;
    logic              relead;
    logic [CP_W-1:0]   min_val;

    logic              m_valid_reg;
    logic [COL_W-1:0]  m_data_reg;

    // a last byte needs a free output register, any other byte never waits
    assign advance  = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        total_next = total_reg;
        need_next  = need_reg;
        seen_next  = seen_reg;
        pv_next    = pv_reg;
        mc_next    = mc_reg;
        stop_next  = stop_reg;
        relead     = 1'b0;
        min_val    = MIN_4B;
        result     = total_reg;
        if (!stop_reg) begin
            if (need_reg == 3'd0) begin
                relead = 1'b1;
            end else if (in_byte_reg[7:6] != 2'b10) begin
                // broken sequence: lead and continuations so far count one each
                total_next = sat_add(total_next, {1'b0, seen_reg} + 4'd1);
                need_next  = 3'd0;
                seen_next  = 3'd0;
                pv_next    = '0;
                mc_next    = CLASS_NONE;
                relead     = 1'b1;
            end else begin
                pv_next   = {pv_reg[CP_W-7:0], in_byte_reg[5:0]};
                seen_next = seen_reg + 3'd1;
                if (({1'b0, seen_next} + 4'd1) >= {1'b0, need_reg}) begin
                    case (mc_reg)
                        CLASS_2B: min_val = MIN_2B;
                        CLASS_3B: min_val = MIN_3B;
                        default:  min_val = MIN_4B;
                    endcase
                    if (pv_next < min_val || pv_next > CP_MAX ||
                        (pv_next >= SURR_LO && pv_next <= SURR_HI)) begin
                        total_next = sat_add(total_next, {1'b0, need_reg});
                    end else begin
                        total_next = add_point(total_next, pv_next);
                    end
                    need_next = 3'd0;
                    seen_next = 3'd0;
                    pv_next   = '0;
                    mc_next   = CLASS_NONE;
                end
            end
            if (relead) begin
                if (in_byte_reg == 8'h00) begin
                    stop_next = 1'b1;
                end else if (!in_byte_reg[7]) begin
                    total_next = add_point(total_next, {13'd0, in_byte_reg});
                end else if (in_byte_reg[7:5] == 3'b110) begin
                    need_next = 3'd2;
                    seen_next = 3'd0;
                    pv_next   = {16'd0, in_byte_reg[4:0]};
                    mc_next   = CLASS_2B;
                end else if (in_byte_reg[7:4] == 4'b1110) begin
                    need_next = 3'd3;
                    seen_next = 3'd0;
                    pv_next   = {17'd0, in_byte_reg[3:0]};
                    mc_next   = CLASS_3B;
                end else if (in_byte_reg[7:3] == 5'b11110) begin
                    need_next = 3'd4;
                    seen_next = 3'd0;
                    pv_next   = {18'd0, in_byte_reg[2:0]};
                    mc_next   = CLASS_4B;
                end else begin
                    total_next = sat_add(total_next, 4'd1);
                end
            end
        end
        if (in_last_reg) begin
            // text cut short inside a sequence
            if (!stop_next && need_next != 3'd0) begin
                total_next = sat_add(total_next, {1'b0, seen_next} + 4'd1);
            end
            result     = total_next;
            total_next = '0;
            need_next  = 3'd0;
            seen_next  = 3'd0;
            pv_next    = '0;
            mc_next    = CLASS_NONE;
            stop_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            need_reg  <= 3'd0;
            seen_reg  <= 3'd0;
            pv_reg    <= '0;
            mc_reg    <= CLASS_NONE;
            stop_reg  <= 1'b0;
        end else if (advance) begin
            total_reg <= total_next;
            need_reg  <= need_next;
            seen_reg  <= seen_next;
            pv_reg    <= pv_next;
            mc_reg    <= mc_next;
            stop_reg  <= stop_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && in_last_reg) begin
            m_data_reg <= result;
        end
    end

    a_need_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        need_reg == 3'd0 || need_reg == 3'd2 || need_reg == 3'd3 || need_reg == 3'd4)
        else $error("pending sequence length out of range");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        need_reg == 3'd0 |-> seen_reg == 3'd0 && pv_reg == '0 && mc_reg == CLASS_NONE)
        else $error("sequence state left over with no sequence pending");

    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        need_reg != 3'd0 |-> ({1'b0, seen_reg} + 4'd1) < {1'b0, need_reg})
        else $error("sequence should have completed");

    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_reg |-> need_reg == 3'd0)
        else $error("sequence pending after stop");

    a_last_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> m_tvalid && total_reg == '0 && !stop_reg)
        else $error("last byte did not emit total and clear state");

endmodule

// ===== bench/utf8_display_column_counter_top_test.sv =====
module utf8_display_column_counter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import u8col_pkg::*;

    localparam int RANDOM_BYTES = 1025;
    localparam int IDLE_PCT     = 22;
    localparam int WATCH_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              last;
        logic              typed;
        logic [COL_W-1:0]  cols;
    } dir_row_t;

    // typed totals only where they follow directly from the byte sequence
    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{8'h41, 1'b1, 1'b1, 16'd1},    // plain ASCII
        '{8'h00, 1'b1, 1'b1, 16'd0},    // NUL alone
        '{8'h09, 1'b1, 1'b1, 16'd8},    // tab from column 0
        '{8'hff, 1'b1, 1'b1, 16'd1},    // bad lead, top of range
        '{8'hc3, 1'b1, 1'b1, 16'd1},    // text ends inside a sequence
        '{8'he4, 1'b0, 1'b0, 16'd0},    // wide CJK
        '{8'hb8, 1'b0, 1'b0, 16'd0},
        '{8'h80, 1'b1, 1'b0, 16'd0},
        '{8'hcc, 1'b0, 1'b0, 16'd0},    // combining mark
        '{8'h80, 1'b1, 1'b0, 16'd0},
        '{8'hc0, 1'b0, 1'b0, 16'd0},    // overlong
        '{8'h80, 1'b1, 1'b1, 16'd2},
        '{8'hed, 1'b0, 1'b0, 16'd0},    // surrogate
        '{8'ha0, 1'b0, 1'b0, 16'd0},
        '{8'h80, 1'b1, 1'b1, 16'd3},
        '{8'hf4, 1'b0, 1'b0, 16'd0},    // above the code space
        '{8'h90, 1'b0, 1'b0, 16'd0},
        '{8'h80, 1'b0, 1'b0, 16'd0},
        '{8'h80, 1'b1, 1'b1, 16'd4},
        '{8'he4, 1'b0, 1'b0, 16'd0},    // bad continuation, retried as lead
        '{8'h41, 1'b1, 1'b1, 16'd2},
        '{8'h00, 1'b0, 1'b0, 16'd0},    // NUL stops the count
        '{8'h80, 1'b0, 1'b0, 16'd0},
        '{8'h7f, 1'b1, 1'b1, 16'd0},
        '{8'h80, 1'b1, 1'b1, 16'd1}     // bad lead, bottom of range
    };

    // range ends of the width table, the encoding classes and the surrogate block, and the tab
    localparam int N_EDGES = 40;
    localparam logic [CP_W-1:0] CP_EDGES [N_EDGES] = '{
        21'h7f, 21'h80, 21'h7ff, 21'h800, 21'h300, 21'h36f, 21'h1ab0, 21'h1aff,
        21'h1dc0, 21'h1dff, 21'h20d0, 21'h20ff, 21'hfe20, 21'hfe2f, 21'h1100,
        21'h115f, 21'h2329, 21'h232a, 21'h2e80, 21'ha4cf, 21'hac00, 21'hd7a3,
        21'hf900, 21'hfaff, 21'hfe10, 21'hfe19, 21'hfe30, 21'hfe6f, 21'hff00,
        21'hff60, 21'hffe0, 21'hffe6, 21'h20000, 21'h3fffd, 21'hd7ff, 21'he000,
        21'hffff, 21'h10000, 21'h10ffff, 21'h09
    };

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [COL_W-1:0]  m_tdata;

    utf8_display_column_counter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [COL_W-1:0] expected_totals [$];
    logic [BYTE_W-1:0] text_q [$];
    bit quiet = 1'b0;
    int errors = 0;
    int texts_sent = 0;
    int bytes_sent = 0;
    int totals_checked = 0;
    int totals_saturated = 0;
    int stalled_cycles = 0;

    // predictor state
    logic [COL_W-1:0] col_sum = '0;
    logic [2:0]       seq_len = '0;
    logic [2:0]       cont_cnt = '0;
    logic [CP_W-1:0]  cp_acc = '0;
    logic [1:0]       min_cls = '0;
    logic             halted = 1'b0;

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit between(input logic [CP_W-1:0] v, input int unsigned lo,
                                   input int unsigned hi);
        return v >= lo && v <= hi;
    endfunction

    function automatic int unsigned glyph_width(input logic [CP_W-1:0] v);
        if (between(v, 'h0300, 'h036f) || between(v, 'h1ab0, 'h1aff) ||
            between(v, 'h1dc0, 'h1dff) || between(v, 'h20d0, 'h20ff) ||
            between(v, 'hfe20, 'hfe2f))
            return 0;
        if (between(v, 'h1100, 'h115f) || between(v, 'h2329, 'h232a) ||
            between(v, 'h2e80, 'ha4cf) || between(v, 'hac00, 'hd7a3) ||
            between(v, 'hf900, 'hfaff) || between(v, 'hfe10, 'hfe19) ||
            between(v, 'hfe30, 'hfe6f) || between(v, 'hff00, 'hff60) ||
            between(v, 'hffe0, 'hffe6) || between(v, 'h20000, 'h3fffd))
            return 2;
        return 1;
    endfunction

    task automatic add_columns(input int unsigned n);
        int unsigned s;
        s = col_sum + n;
        col_sum = (s > COL_MAX) ? COL_MAX : s[COL_W-1:0];
    endtask

    task automatic put_point(input logic [CP_W-1:0] v);
        if (v == CP_TAB)
            add_columns(8 - col_sum[2:0]);
        else
            add_columns(glyph_width(v));
    endtask

    task automatic drop_seq();
        seq_len = '0;
        cont_cnt = '0;
        cp_acc = '0;
        min_cls = '0;
    endtask

    task automatic open_seq(input logic [BYTE_W-1:0] b);
        if (b == 8'h00) begin
            halted = 1'b1;
        end else if (b < 8'h80) begin
            put_point({13'd0, b});
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            if (b[7:5] == 3'b110) begin
                seq_len = 3'd2;
                cp_acc = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                seq_len = 3'd3;
                cp_acc = {17'd0, b[3:0]};
            end else begin
                seq_len = 3'd4;
                cp_acc = {18'd0, b[2:0]};
            end
            cont_cnt = '0;
            min_cls = 2'(seq_len - 3'd1);
        end else begin
            add_columns(1);
        end
    endtask

    task automatic predict_columns(input logic [BYTE_W-1:0] b, input logic last,
                                   output bit emit, output logic [COL_W-1:0] total);
        logic [CP_W-1:0] floor_v;
        emit = 1'b0;
        total = '0;
        if (!halted) begin
            if (seq_len == 0) begin
                open_seq(b);
            end else if (b[7:6] != 2'b10) begin
                add_columns(1 + cont_cnt);
                drop_seq();
                open_seq(b);
            end else begin
                cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
                cont_cnt = cont_cnt + 3'd1;
                if (int'(cont_cnt) + 1 >= int'(seq_len)) begin
                    floor_v = (min_cls == CLASS_2B) ? MIN_2B :
                              (min_cls == CLASS_3B) ? MIN_3B : MIN_4B;
                    if (cp_acc < floor_v || cp_acc > CP_MAX ||
                        (cp_acc >= SURR_LO && cp_acc <= SURR_HI))
                        add_columns(seq_len);
                    else
                        put_point(cp_acc);
                    drop_seq();
                end
            end
        end
        if (last) begin
            if (!halted && seq_len != 0)
                add_columns(1 + cont_cnt);
            emit = 1'b1;
            total = col_sum;
            col_sum = '0;
            halted = 1'b0;
            drop_seq();
        end
    endtask

    function automatic bit take_break();
        return !quiet && $urandom_range(99) < IDLE_PCT;
    endfunction

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last,
                             input logic typed, input logic [COL_W-1:0] typed_cols);
        bit emit;
        logic [COL_W-1:0] total;
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        bytes_sent++;
        predict_columns(b, last, emit, total);
        if (emit) begin
            texts_sent++;
            expected_totals.push_back(typed ? typed_cols : total);
        end
    endtask

    function automatic int min_len(input logic [CP_W-1:0] v);
        return v < 'h80 ? 1 : v < 'h800 ? 2 : v < 'h10000 ? 3 : 4;
    endfunction

    // append v as an n-byte sequence; n above the minimum gives an overlong form
    task automatic append_cp(input logic [CP_W-1:0] v, input int n);
        case (n)
            1: text_q.push_back({1'b0, v[6:0]});
            2: text_q.push_back({3'b110, v[10:6]});
            3: text_q.push_back({4'b1110, v[15:12]});
            default: text_q.push_back({5'b11110, v[20:18]});
        endcase
        for (int k = n - 2; k >= 0; k--)
            text_q.push_back({2'b10, v[6*k +: 6]});
    endtask

    function automatic logic [CP_W-1:0] pick_cp();
        logic [CP_W-1:0] v;
        if ($urandom_range(1)) begin
            v = CP_EDGES[$urandom_range(N_EDGES - 1)] + CP_W'($urandom_range(2)) - 1'b1;
        end else begin
            case ($urandom_range(3))
                0: v = CP_W'($urandom_range('h7f, 1));
                1: v = CP_W'($urandom_range('h7ff, 'h80));
                2: v = CP_W'($urandom_range('hffff, 'h800));
                default: v = CP_W'($urandom_range('h10ffff, 'h10000));
            endcase
        end
        return v == 0 ? CP_W'(1) : v;
    endfunction

    task automatic build_text();
        int units;
        int n;
        int sel;
        int idx;
        logic [CP_W-1:0] v;
        logic [BYTE_W-1:0] bad;
        units = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(10, 1);
        text_q.delete();
        repeat (units) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                v = pick_cp();
                append_cp(v, min_len(v));
            end else if (sel < 60) begin
                text_q.push_back($urandom_range(3) == 0 ? 8'h09 : 8'($urandom_range(127, 1)));
            end else if (sel < 70) begin
                case ($urandom_range(2))
                    0: begin
                        v = CP_W'($urandom_range('hffff, 0));
                        n = min_len(v) + $urandom_range(4 - (min_len(v) < 4 ? min_len(v) : 3), 1);
                        append_cp(v, n > 4 ? 4 : n);
                    end
                    1: append_cp(CP_W'($urandom_range('hdfff, 'hd800)), 3);
                    default: append_cp(CP_W'($urandom_range('h1fffff, 'h110000)), 4);
                endcase
            end else if (sel < 80) begin
                n = $urandom_range(4, 2);
                append_cp(CP_W'($urandom), n);
                repeat ($urandom_range(n - 1, 1)) void'(text_q.pop_back());
            end else if (sel < 88) begin
                n = $urandom_range(4, 2);
                append_cp(pick_cp(), n);
                idx = text_q.size() - n + $urandom_range(n - 1, 1);
                bad = 8'($urandom_range(255));
                if (bad[7:6] == 2'b10)
                    bad[7] = 1'b0;
                text_q[idx] = bad;
            end else if (sel < 98) begin
                text_q.push_back(8'($urandom_range(255, 1)));
            end else begin
                text_q.push_back(8'h00);
            end
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= quiet || $urandom_range(99) >= IDLE_PCT;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_totals.size() == 0) begin
                flag_error($sformatf("total %0d with no text pending", m_tdata));
            end else begin
                if (m_tdata !== expected_totals[0])
                    flag_error($sformatf("columns got %0d want %0d", m_tdata,
                                         expected_totals[0]));
                if (expected_totals[0] == COL_MAX)
                    totals_saturated++;
                void'(expected_totals.pop_front());
                totals_checked++;
            end
        end
    end

    // stop if neither side moves a beat for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCH_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCH_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i])
            send_beat(DIRECTED[i].text_byte, DIRECTED[i].last, DIRECTED[i].typed,
                      DIRECTED[i].cols);

        begin
            int first_byte;
            int t;
            first_byte = bytes_sent;
            t = 0;
            while (bytes_sent - first_byte < RANDOM_BYTES) begin
                quiet = (t >= 15 && t < 40);
                build_text();
                foreach (text_q[i])
                    send_beat(text_q[i], i == text_q.size() - 1, 1'b0, '0);
                t++;
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (expected_totals.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d texts in %0d bytes: ASCII, tabs, wide and combining ranges,",
                 texts_sent, bytes_sent);
        $display("malformed and cut-short sequences, NUL stops; %0d totals checked, %0d saturated",
                 totals_checked, totals_saturated);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/u8col_pkg.sv
src/utf8_display_column_counter_top.sv
bench/utf8_display_column_counter_top_test.sv
